// ----- sv/trcm_pkg.sv -----
// ----------------------------------------------------------------------------
// trcm_pkg
// Types and constants shared by the transfer rate change monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package trcm_pkg;

  localparam int unsigned RATE_W   = 32;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned PERIOD_W = 12;
  localparam int unsigned BYTE_SHIFT = 3;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic REG_PERIOD    = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1);

  typedef struct packed {
    logic              op;
    logic              size_valid;
    logic [SIZE_W-1:0] current_size;
  } trcm_in_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate_bps;
    logic              rate_changed;
  } trcm_out_t;

endpackage

`default_nettype wire

// ----- sv/transfer_rate_change_monitor.sv -----
// ----------------------------------------------------------------------------
// transfer_rate_change_monitor
// Turns cumulative byte counts into a bits-per-second rate with a bit-serial
// divider and flags rate moves of at least the configured threshold.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  in_      | input     | in_valid / in_ready  | trcm_in_t  (op, size_valid, current_size)
//  out_     | output    | out_valid/ out_ready | trcm_out_t (rate_bps, rate_changed)
//  cfg_     | input     | APB, pready tied 1   | 0x0 period_seconds, 0x4 change_threshold
//
//  Valid tick: 32 divider steps, one quotient bit per cycle, then difference,
//  magnitude, compare and output load.
//  Clear item and invalid tick: straight from accept to output load, no divider.
//  One item in flight; in_ready is high only while the sequencer is idle.
//  A result waits in the output register while out_ready is low; the next
//  item is accepted meanwhile and holds in its last step until the register frees.
//  Synchronous active-low reset clears all rate state; period resets to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module transfer_rate_change_monitor
  import trcm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire trcm_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output trcm_out_t                  out_data,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DIFF,
    S_MAG,
    S_CMP,
    S_EMIT
  } state_t;

  localparam logic [4:0] LAST_STEP = 5'(RATE_W - 1);

  state_t              state_r;
  logic [4:0]          cnt_r;
  logic [PERIOD_W-1:0] period_r;
  logic [RATE_W-1:0]   threshold_r;
  logic [SIZE_W-1:0]   last_size_r;
  logic [RATE_W-1:0]   current_rate_r;
  logic [RATE_W-1:0]   reference_rate_r;
  logic [RATE_W-1:0]   quo_r;
  logic [PERIOD_W-1:0] rem_r;
  logic [RATE_W-1:0]   diff_r;
  logic [RATE_W-1:0]   mag_r;
  logic                out_valid_r;
  trcm_out_t           out_data_r;
  trcm_out_t           res_r;

  logic                cfg_write;
  logic                in_accept;
  logic                out_free;
  logic [PERIOD_W:0]   rem_sh;
  logic [PERIOD_W:0]   rem_sub;
  logic                rem_ge;
  logic [SIZE_W-1:0]   size_delta;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_THRESHOLD) ? threshold_r
                                                       : CFG_DATA_W'(period_r);

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign rem_sh     = {rem_r, quo_r[RATE_W-1]};
  assign rem_ge     = (rem_sh >= {1'b0, period_r});
  assign rem_sub    = rem_sh - {1'b0, period_r};
  assign size_delta = in_data.current_size - last_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RESET;
      threshold_r <= '0;
    end else if (cfg_write) begin
      if (cfg_paddr[2] == REG_THRESHOLD) begin
        threshold_r <= cfg_pwdata;
      end else begin
        period_r <= cfg_pwdata[PERIOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      cnt_r            <= '0;
      last_size_r      <= '0;
      current_rate_r   <= '0;
      reference_rate_r <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            if (in_data.op == OP_CLEAR) begin
              last_size_r      <= '0;
              current_rate_r   <= '0;
              reference_rate_r <= '0;
              res_r            <= '{rate_bps: '0, rate_changed: 1'b0};
              state_r          <= S_EMIT;
            end else if (in_data.size_valid) begin
              quo_r       <= size_delta << BYTE_SHIFT;
              rem_r       <= '0;
              cnt_r       <= '0;
              last_size_r <= in_data.current_size;
              state_r     <= S_DIV;
            end else begin
              res_r   <= '{rate_bps: current_rate_r, rate_changed: 1'b0};
              state_r <= S_EMIT;
            end
          end
        end
        S_DIV: begin
          quo_r <= {quo_r[RATE_W-2:0], rem_ge};
          rem_r <= rem_ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == LAST_STEP) begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF: begin
          current_rate_r <= quo_r;
          diff_r         <= quo_r - reference_rate_r;
          state_r        <= S_MAG;
        end
        S_MAG: begin
          mag_r   <= diff_r[RATE_W-1] ? (RATE_W'(0) - diff_r) : diff_r;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (mag_r >= threshold_r) begin
            reference_rate_r <= current_rate_r;
            res_r <= '{rate_bps: current_rate_r, rate_changed: 1'b1};
          end else begin
            res_r <= '{rate_bps: current_rate_r, rate_changed: 1'b0};
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == LAST_STEP) |=> (state_r == S_DIFF))
    else $error("divider did not finish after the last step");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.op == OP_CLEAR) |=>
      (last_size_r == '0 && current_rate_r == '0 && reference_rate_r == '0))
    else $error("clear item left rate state nonzero");

  a_ref_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP && mag_r >= threshold_r) |=>
      (reference_rate_r == current_rate_r && res_r.rate_changed))
    else $error("reference rate not taken on a flagged change");

  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=> (out_valid_r && out_data_r == $past(res_r)))
    else $error("result not loaded into the output register");

endmodule

`default_nettype wire

// ----- bench/tb_transfer_rate_change_monitor.sv -----
// ----------------------------------------------------------------------------
// tb_transfer_rate_change_monitor
// Drives tick and clear items with bursty valid and a stalling result side,
// predicts each rate and change flag, and checks every result in order.
// Registers are rewritten between phases, including zero period and
// threshold extremes.
// ----------------------------------------------------------------------------
module tb_transfer_rate_change_monitor;
  timeunit 1ns;
  timeprecision 1ps;
  import trcm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned PHASE_COUNT  = 8;
  localparam int unsigned PRESS_ITEMS  = 24;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  trcm_in_t              in_data     = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  trcm_out_t             out_data;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  logic [SIZE_W-1:0]   size_seen      = '0;
  logic [RATE_W-1:0]   rate_now       = '0;
  logic [RATE_W-1:0]   rate_reported  = '0;
  logic [PERIOD_W-1:0] period_cfg     = PERIOD_RESET;
  logic [RATE_W-1:0]   threshold_cfg  = '0;
  trcm_out_t           expected_rates[$];

  int unsigned       error_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       hold_cycles = 0;
  int unsigned       burst_left  = 0;
  bit                sender_gaps = 1'b0;
  rx_mode_t          rx_mode     = RX_ALWAYS;
  logic [7:0]        rx_pattern  = 8'b1011_0110;
  logic [SIZE_W-1:0] byte_count  = '0;
  logic [SIZE_W-1:0] steady_inc  = 32'd1000;

  transfer_rate_change_monitor u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_transfer_rate_change_monitor NOT OK");
      $finish;
    end
  end

  function automatic trcm_out_t rate_after_item(input trcm_in_t item);
    logic [RATE_W-1:0] bits;
    logic [RATE_W-1:0] delta;
    logic [RATE_W-1:0] distance;
    trcm_out_t         res;
    res.rate_changed = 1'b0;
    if (item.op == OP_CLEAR) begin
      size_seen     = '0;
      rate_now      = '0;
      rate_reported = '0;
    end else if (item.size_valid) begin
      bits      = item.current_size - size_seen;
      bits      = bits << BYTE_SHIFT;
      rate_now  = (period_cfg == '0) ? '1 : bits / RATE_W'(period_cfg);
      size_seen = item.current_size;
      delta     = rate_now - rate_reported;
      distance  = delta[RATE_W-1] ? -delta : delta;
      if (distance >= threshold_cfg) begin
        rate_reported    = rate_now;
        res.rate_changed = 1'b1;
      end
    end
    res.rate_bps = rate_now;
    return res;
  endfunction

  function automatic trcm_in_t make_item(input logic op, input logic size_valid,
                                         input logic [SIZE_W-1:0] size);
    trcm_in_t item;
    item.op           = op;
    item.size_valid   = size_valid;
    item.current_size = size;
    return item;
  endfunction

  // Mostly steady byte counts; the rest are clears, invalid ticks and jumps.
  function automatic trcm_in_t random_item();
    int unsigned       roll;
    logic [SIZE_W-1:0] inc;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      byte_count = '0;
      return make_item(OP_CLEAR, 1'($urandom), $urandom);
    end
    if (roll < 20) return make_item(OP_TICK, 1'b0, $urandom);
    if (roll < 28) begin
      byte_count = $urandom;
      return make_item(OP_TICK, 1'b1, byte_count);
    end
    if (roll < 80) inc = steady_inc + $urandom_range(0, steady_inc >> 3);
    else inc = $urandom >> $urandom_range(0, 31);
    byte_count = byte_count + inc;
    return make_item(OP_TICK, 1'b1, byte_count);
  endfunction

  task automatic send_item(input trcm_in_t item);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    expected_rates.push_back(rate_after_item(item));
    if (sender_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 15);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic reg_idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] readback;
    logic [CFG_DATA_W-1:0] stored;
    logic [CFG_ADDR_W-1:0] addr;
    addr = CFG_ADDR_W'({reg_idx, 2'b00});
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (reg_idx == REG_PERIOD) period_cfg = value[PERIOD_W-1:0];
    else threshold_cfg = value;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    stored = (reg_idx == REG_PERIOD) ? CFG_DATA_W'(period_cfg) : threshold_cfg;
    if (readback !== stored) begin
      $display("%0t: register %0d readback expected %h actual %h",
               $time, reg_idx, stored, readback);
      error_count++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_RANDOM: begin
          out_ready <= ($urandom_range(0, 2) != 0);
          if ($urandom_range(0, 199) == 0) hold_cycles = $urandom_range(5, 40);
        end
        default: begin
          out_ready  <= rx_pattern[0];
          rx_pattern <= {rx_pattern[0], rx_pattern[7:1]};
        end
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    trcm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rates.size() == 0) begin
        $display("%0t: unexpected result rate_bps %h rate_changed %b",
                 $time, out_data.rate_bps, out_data.rate_changed);
        error_count++;
      end else begin
        want = expected_rates.pop_front();
        if (out_data.rate_bps !== want.rate_bps) begin
          $display("%0t: rate_bps expected %h actual %h",
                   $time, want.rate_bps, out_data.rate_bps);
          error_count++;
        end
        if (out_data.rate_changed !== want.rate_changed) begin
          $display("%0t: rate_changed expected %b actual %b",
                   $time, want.rate_changed, out_data.rate_changed);
          error_count++;
        end
      end
    end
  end

  task automatic test_extremes();
    send_item(make_item(OP_TICK, 1'b1, 32'h0000_0000));
    send_item(make_item(OP_TICK, 1'b1, 32'hFFFF_FFFF));
    send_item(make_item(OP_TICK, 1'b1, 32'h0000_0000));
    send_item(make_item(OP_TICK, 1'b0, 32'hFFFF_FFFF));
    send_item(make_item(OP_TICK, 1'b0, 32'h0000_0000));
    wait_drained();
    write_reg(REG_PERIOD, 32'd4095);
    write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
    send_item(make_item(OP_TICK, 1'b1, 32'hFFFF_FFFF));
    send_item(make_item(OP_TICK, 1'b1, 32'h0000_0000));
    wait_drained();
  endtask

  task automatic test_clear_and_invalid();
    send_item(make_item(OP_CLEAR, 1'b1, 32'hFFFF_FFFF));
    send_item(make_item(OP_TICK, 1'b1, 32'd100));
    send_item(make_item(OP_CLEAR, 1'b0, 32'h0000_0000));
    send_item(make_item(OP_TICK, 1'b0, 32'd5000));
    wait_drained();
  endtask

  task automatic test_zero_period();
    write_reg(REG_PERIOD, 32'd0);
    write_reg(REG_THRESHOLD, 32'd0);
    send_item(make_item(OP_TICK, 1'b1, 32'd5));
    send_item(make_item(OP_TICK, 1'b1, 32'd5));
    send_item(make_item(OP_CLEAR, 1'b0, 32'd0));
    wait_drained();
  endtask

  task automatic test_distance_limit();
    write_reg(REG_PERIOD, 32'd1);
    write_reg(REG_THRESHOLD, 32'h8000_0000);
    send_item(make_item(OP_TICK, 1'b1, 32'h1000_0000));
    send_item(make_item(OP_CLEAR, 1'b0, 32'd0));
    wait_drained();
    write_reg(REG_THRESHOLD, 32'h8000_0001);
    send_item(make_item(OP_TICK, 1'b1, 32'h1000_0000));
    send_item(make_item(OP_TICK, 1'b1, 32'h2000_0000));
    send_item(make_item(OP_TICK, 1'b1, 32'h2000_0001));
    wait_drained();
  endtask

  // Hold the result side long enough that the block stalls its input.
  task automatic test_backpressure();
    sender_gaps = 1'b0;
    rx_mode     = RX_ALWAYS;
    hold_cycles = 300;
    repeat (PRESS_ITEMS) send_item(random_item());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [PERIOD_W-1:0] period;
    logic [RATE_W-1:0]   threshold;
    logic [RATE_W-1:0]   typical;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      steady_inc = $urandom >> $urandom_range(3, 28);
      case (phase)
        0:       period = 12'd1;
        1, 7:    period = 12'd4095;
        2:       period = 12'd0;
        4:       period = 12'd1;
        6:       period = PERIOD_W'($urandom_range(1, 8));
        default: period = PERIOD_W'($urandom_range(1, 4095));
      endcase
      typical = (period == '0) ? '1 : (steady_inc << BYTE_SHIFT) / RATE_W'(period);
      case (phase)
        0, 5:    threshold = '0;
        1:       threshold = '1;
        default: threshold = typical >> $urandom_range(0, 8);
      endcase
      case (phase % 3)
        0:       rx_mode = RX_RANDOM;
        1:       rx_mode = RX_PATTERN;
        default: rx_mode = RX_ALWAYS;
      endcase
      sender_gaps = (phase != 0 && phase != 4);
      wait_drained();
      write_reg(REG_PERIOD, ($urandom & 32'hFFFF_F000) | CFG_DATA_W'(period));
      write_reg(REG_THRESHOLD, threshold);
      repeat (PHASE_ITEMS) send_item(random_item());
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_clear_and_invalid();
    test_zero_period();
    test_distance_limit();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_transfer_rate_change_monitor OK");
    end else begin
      $display("tb_transfer_rate_change_monitor NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/trcm_pkg.sv
sv/transfer_rate_change_monitor.sv
bench/tb_transfer_rate_change_monitor.sv
